// ===== design/bdtp_pkg.sv =====
// ----------------------------------------------------------------------------
// bdtp_pkg
// Shared types and constants of the branch direction and target predictor.
// ----------------------------------------------------------------------------
package bdtp_pkg;

    // Width of every address and total field on the ports.
    localparam int FIELD_BITS = 48;

    // Two-bit saturating counter states.
    typedef enum logic [1:0] {
        CTR_SNT = 2'd0,
        CTR_WNT = 2'd1,
        CTR_WT  = 2'd2,
        CTR_ST  = 2'd3
    } t_ctr;

    // Configuration register value that selects the two-bit predictor.
    localparam logic MODE_TWO_BIT = 1'b1;

    typedef struct packed {
        logic [FIELD_BITS-1:0] branch_pc;
        logic [FIELD_BITS-1:0] branch_target;
        logic                  branch_taken;
    } t_in;

    typedef struct packed {
        logic                  predicted_taken;
        logic [FIELD_BITS-1:0] predicted_target;
        logic                  direction_miss;
        logic                  target_miss;
        logic [FIELD_BITS-1:0] direction_miss_total;
        logic [FIELD_BITS-1:0] target_miss_total;
        logic [FIELD_BITS-1:0] miss_total;
        logic [FIELD_BITS-1:0] hit_total;
    } t_out;

endpackage

// ===== design/bdtp_table.sv =====
// ----------------------------------------------------------------------------
// bdtp_table
// Predictor entry memory: direction bit, counter and target per entry, with
// a clearing sweep after reset and same-index forwarding of the write.
// ----------------------------------------------------------------------------
module bdtp_table #(
    parameter int ENTRIES   = 4096,
    parameter int ADDR_BITS = 48,
    parameter int IDX_BITS  = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [IDX_BITS-1:0]  i_rd_idx,
    input  logic                 i_wr_en,
    input  logic [IDX_BITS-1:0]  i_wr_idx,
    input  logic                 i_wr_dir,
    input  logic [1:0]           i_wr_ctr,
    input  logic [ADDR_BITS-1:0] i_wr_target,
    output logic                 o_rd_dir,
    output logic [1:0]           o_rd_ctr,
    output logic [ADDR_BITS-1:0] o_rd_target,
    output logic                 o_clearing
);

    localparam int EW = ADDR_BITS + 3;
    localparam logic [IDX_BITS-1:0] LAST_IDX = IDX_BITS'(ENTRIES - 1);

    // Entry layout: {target, counter, direction}.
    logic [EW-1:0] r_mem [ENTRIES];
    logic [EW-1:0] r_rd_data;
    logic [EW-1:0] r_fwd_data;
    logic          r_fwd;

    logic                r_clr_busy;
    logic [IDX_BITS-1:0] r_clr_idx;

    logic                w_we;
    logic [IDX_BITS-1:0] w_widx;
    logic [EW-1:0]       w_wdata;
    logic [EW-1:0]       w_wr_entry;
    logic [EW-1:0]       w_rd_entry;

    assign w_wr_entry = {i_wr_target, i_wr_ctr, i_wr_dir};

    // The sweep owns the write port until every entry holds its reset value.
    always_comb begin
        if (r_clr_busy) begin
            w_we    = 1'b1;
            w_widx  = r_clr_idx;
            w_wdata = {ADDR_BITS'(0), bdtp_pkg::CTR_WNT, 1'b0};
        end else begin
            w_we    = i_wr_en;
            w_widx  = i_wr_idx;
            w_wdata = w_wr_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clr_busy) begin
            r_clr_idx <= r_clr_idx + IDX_BITS'(1);
            if (r_clr_idx == LAST_IDX) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_widx] <= w_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data  <= r_mem[i_rd_idx];
            r_fwd_data <= w_wr_entry;
        end
    end

    // A read that meets a write to the same entry at the same edge takes the
    // new entry instead of the old memory contents.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd_en) begin
            r_fwd <= i_wr_en && (i_wr_idx == i_rd_idx);
        end
    end

    assign w_rd_entry  = r_fwd ? r_fwd_data : r_rd_data;
    assign o_rd_dir    = w_rd_entry[0];
    assign o_rd_ctr    = w_rd_entry[2:1];
    assign o_rd_target = w_rd_entry[EW-1:3];
    assign o_clearing  = r_clr_busy;

endmodule

// ===== design/branch_direction_target_predictor.sv =====
// ----------------------------------------------------------------------------
// branch_direction_target_predictor
// Direction and target predictor with a branch target buffer, fed with
// resolved direct branches; reports misses and keeps saturating totals.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Payload
//  --------  ---------  ------------------------  --------------------------
//  in        input      i_in_valid / o_in_ready   i_in_data  (bdtp_pkg::t_in)
//  out       output     o_out_valid / i_out_ready o_out_data (bdtp_pkg::t_out)
//  cfg       input      i_cfg_we                  i_cfg_wdata (predictor mode)
//
//  One branch is taken every cycle unless the result register stalls or the
//  clearing sweep runs. The input transfer loads the input register and issues
//  the entry read; the edge that next advances the pipeline writes the entry
//  back and loads the result register. TABLE_ENTRIES must be a power of two,
//  unchecked by the block, so the table index is the low PC bits. After reset a
//  clearing sweep writes every entry with o_in_ready low; configuration writes
//  are taken as ever. A stalled result register holds the input register too.
// ----------------------------------------------------------------------------
module branch_direction_target_predictor #(
    parameter int TABLE_ENTRIES = 4096,
    parameter int ADDRESS_BITS  = 48,
    parameter int COUNT_BITS    = 48
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  bdtp_pkg::t_in   i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output bdtp_pkg::t_out  o_out_data,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata
);

    // Table index width.
    localparam int IW = $clog2(TABLE_ENTRIES);

    // Handshake and global pipeline advance. Every stage moves together when
    // the result register is empty or its result is being transferred.
    logic w_en;
    logic w_clearing;
    logic w_in_acc;

    assign w_en       = !o_out_valid || i_out_ready;
    assign o_in_ready = w_en && !w_clearing;
    assign w_in_acc   = i_in_valid && o_in_ready;

    // Predictor mode register.
    logic r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_mode <= i_cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Input register: the entry read is issued as the item enters this
    // stage, so its data is ready while the item sits here.
    // ------------------------------------------------------------------
    logic          r_m_valid;
    bdtp_pkg::t_in r_m_item;
    logic [IW-1:0] r_m_idx;
    logic [IW-1:0] w_in_idx;

    // The PC modulo TABLE_ENTRIES is simply its low bits.
    assign w_in_idx = i_in_data.branch_pc[IW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (w_en) begin
            r_m_valid <= w_in_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_m_item <= i_in_data;
            r_m_idx  <= w_in_idx;
        end
    end

    logic                    w_rd_dir;
    logic [1:0]              w_rd_ctr;
    logic [ADDRESS_BITS-1:0] w_rd_target;
    logic                    w_wr_dir;
    logic [1:0]              w_wr_ctr;
    logic [ADDRESS_BITS-1:0] w_wr_target;
    logic                    w_wr_en;

    // The entry is written back at the edge that moves the item into the
    // result register, so the next item reading the same entry is forwarded.
    assign w_wr_en = w_en && r_m_valid;

    bdtp_table #(
        .ENTRIES   (TABLE_ENTRIES),
        .ADDR_BITS (ADDRESS_BITS),
        .IDX_BITS  (IW)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rd_en     (w_en),
        .i_rd_idx    (w_in_idx),
        .i_wr_en     (w_wr_en),
        .i_wr_idx    (r_m_idx),
        .i_wr_dir    (w_wr_dir),
        .i_wr_ctr    (w_wr_ctr),
        .i_wr_target (w_wr_target),
        .o_rd_dir    (w_rd_dir),
        .o_rd_ctr    (w_rd_ctr),
        .o_rd_target (w_rd_target),
        .o_clearing  (w_clearing)
    );

    // ------------------------------------------------------------------
    // Prediction check and entry update.
    // ------------------------------------------------------------------
    logic [ADDRESS_BITS-1:0] w_tgt;
    logic                    w_taken;
    logic                    w_dmiss;
    logic                    w_tmiss;

    assign w_tgt   = ADDRESS_BITS'(r_m_item.branch_target);
    assign w_taken = r_m_item.branch_taken;
    assign w_dmiss = w_rd_dir != w_taken;
    assign w_tmiss = w_rd_target != w_tgt;

    always_comb begin
        w_wr_dir    = w_taken;
        w_wr_ctr    = w_rd_ctr;
        w_wr_target = w_taken ? w_tgt : w_rd_target;
        if (r_mode == bdtp_pkg::MODE_TWO_BIT) begin
            case (bdtp_pkg::t_ctr'(w_rd_ctr))
                bdtp_pkg::CTR_SNT: begin
                    w_wr_ctr    = w_taken ? bdtp_pkg::CTR_WNT : bdtp_pkg::CTR_SNT;
                    w_wr_dir    = 1'b0;
                    w_wr_target = w_rd_target;
                end
                bdtp_pkg::CTR_WNT: begin
                    w_wr_ctr = w_taken ? bdtp_pkg::CTR_WT : bdtp_pkg::CTR_SNT;
                end
                bdtp_pkg::CTR_WT: begin
                    w_wr_ctr = w_taken ? bdtp_pkg::CTR_ST : bdtp_pkg::CTR_WNT;
                end
                default: begin
                    // Strong taken rewrites the target even on a not-taken
                    // outcome.
                    w_wr_ctr    = w_taken ? bdtp_pkg::CTR_ST : bdtp_pkg::CTR_WT;
                    w_wr_dir    = 1'b1;
                    w_wr_target = w_tgt;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Saturating totals.
    // ------------------------------------------------------------------
    logic [COUNT_BITS-1:0] r_dmiss_cnt, n_dmiss_cnt;
    logic [COUNT_BITS-1:0] r_tmiss_cnt, n_tmiss_cnt;
    logic [COUNT_BITS-1:0] r_miss_cnt,  n_miss_cnt;
    logic [COUNT_BITS-1:0] r_hit_cnt,   n_hit_cnt;
    logic                  w_any_miss;

    assign w_any_miss = w_dmiss || w_tmiss;

    always_comb begin
        n_dmiss_cnt = r_dmiss_cnt;
        n_tmiss_cnt = r_tmiss_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_hit_cnt   = r_hit_cnt;
        if (w_dmiss && (r_dmiss_cnt != '1)) begin
            n_dmiss_cnt = r_dmiss_cnt + COUNT_BITS'(1);
        end
        if (w_tmiss && (r_tmiss_cnt != '1)) begin
            n_tmiss_cnt = r_tmiss_cnt + COUNT_BITS'(1);
        end
        if (w_any_miss && (r_miss_cnt != '1)) begin
            n_miss_cnt = r_miss_cnt + COUNT_BITS'(1);
        end
        if (!w_any_miss && (r_hit_cnt != '1)) begin
            n_hit_cnt = r_hit_cnt + COUNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dmiss_cnt <= '0;
            r_tmiss_cnt <= '0;
            r_miss_cnt  <= '0;
            r_hit_cnt   <= '0;
        end else if (w_wr_en) begin
            r_dmiss_cnt <= n_dmiss_cnt;
            r_tmiss_cnt <= n_tmiss_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_hit_cnt   <= n_hit_cnt;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    logic           r_out_valid;
    bdtp_pkg::t_out r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_out_valid <= r_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_out.predicted_taken      <= w_rd_dir;
            r_out.predicted_target     <= bdtp_pkg::FIELD_BITS'(w_rd_target);
            r_out.direction_miss       <= w_dmiss;
            r_out.target_miss          <= w_tmiss;
            r_out.direction_miss_total <= bdtp_pkg::FIELD_BITS'(n_dmiss_cnt);
            r_out.target_miss_total    <= bdtp_pkg::FIELD_BITS'(n_tmiss_cnt);
            r_out.miss_total           <= bdtp_pkg::FIELD_BITS'(n_miss_cnt);
            r_out.hit_total            <= bdtp_pkg::FIELD_BITS'(n_hit_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

`ifndef NO_ASSERTIONS
    // No item can reach the memory stage while the clearing sweep runs.
    a_no_item_while_clearing: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_clearing |-> !r_m_valid
    ) else $error("item in memory stage during clearing sweep");

    // A fully correct branch leaves the miss total alone.
    a_hit_keeps_miss_total: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && !w_any_miss) |=> (r_miss_cnt == $past(r_miss_cnt))
    ) else $error("miss total moved on a hit");

    // A direction miss below saturation advances the miss total by one.
    a_dmiss_counts: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_en && w_dmiss && (r_miss_cnt != '1))
            |=> (r_miss_cnt == $past(r_miss_cnt) + COUNT_BITS'(1))
    ) else $error("direction miss not counted in miss total");

    // A result becomes valid only from an item that was in the memory stage.
    a_result_has_source: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_m_valid)
    ) else $error("result appeared without an item");
`endif

endmodule

// ===== tb/sv/branch_direction_target_predictor_tb.sv =====
// ----------------------------------------------------------------------------
// branch_direction_target_predictor_tb
// Self-checking bench for the branch direction and target predictor. Resolved
// branches go in over a valid/ready channel. A predictor model in the bench
// keeps its own direction, target and counter tables and its own totals, and
// each result transfer is compared field by field with the oldest prediction.
// Directed branches walk both predictor modes and the mode switch. Random
// traffic follows, made mostly of recurring branches with random content.
// ----------------------------------------------------------------------------
module branch_direction_target_predictor_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // The block is built with its default sizes, so the bench mirrors them.
    localparam int TABLE_SIZE = 4096;
    localparam int ADDR_BITS  = bdtp_pkg::FIELD_BITS;

    // The input register, then the result register.
    localparam int PIPE_LATENCY = 2;

    // The longest quiet stretch in a correct run is the clearing sweep after
    // reset, which writes every table entry. The limit leaves a wide margin.
    localparam int WATCHDOG_LIMIT = 4 * TABLE_SIZE + 1000;

    localparam logic MODE_ONE_BIT = ~bdtp_pkg::MODE_TWO_BIT;

    // Number of printed mismatch lines before the bench only counts them.
    localparam int MAX_PRINTED = 40;

    // Random traffic: recurring branches live in a small pool of addresses.
    localparam int POOL_SIZE   = 32;
    localparam int PHASE_ITEMS = 185;
    localparam int PHASES      = 6;

    // ------------------------------------------------------------------------
    // Signals of the block.
    // ------------------------------------------------------------------------
    logic           i_clk       = 1'b0;
    logic           i_rst_n     = 1'b0;
    logic           i_in_valid  = 1'b0;
    logic           o_in_ready;
    bdtp_pkg::t_in  i_in_data   = '0;
    logic           o_out_valid;
    logic           i_out_ready = 1'b0;
    bdtp_pkg::t_out o_out_data;
    logic           i_cfg_we    = 1'b0;
    logic           i_cfg_wdata = 1'b0;

    branch_direction_target_predictor u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // ------------------------------------------------------------------------
    // Bench state.
    // ------------------------------------------------------------------------

    // Predictor model: its own copy of the three tables, the four totals
    // and the mode register.
    logic                            dir_bits    [TABLE_SIZE];
    logic [ADDR_BITS-1:0]            btb_targets [TABLE_SIZE];
    bdtp_pkg::t_ctr                  ctr_states  [TABLE_SIZE];
    logic [bdtp_pkg::FIELD_BITS-1:0] dir_miss_cnt;
    logic [bdtp_pkg::FIELD_BITS-1:0] tgt_miss_cnt;
    logic [bdtp_pkg::FIELD_BITS-1:0] any_miss_cnt;
    logic [bdtp_pkg::FIELD_BITS-1:0] hit_cnt;
    logic                            two_bit_mode;

    // Predicted results in the order their branches were transferred.
    bdtp_pkg::t_out pending_results[$];

    int error_count     = 0;
    int branches_sent   = 0;
    int results_checked = 0;
    int mode_writes     = 0;
    int stall_cycles    = 0;

    // While set, neither side of the bench inserts idle cycles.
    logic steady = 1'b0;

    // ------------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------------
    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor model.
    // ------------------------------------------------------------------------
    task automatic clear_model();
        for (int i = 0; i < TABLE_SIZE; i++) begin
            dir_bits[i]    = 1'b0;
            btb_targets[i] = '0;
            ctr_states[i]  = bdtp_pkg::CTR_WNT;
        end
        dir_miss_cnt = '0;
        tgt_miss_cnt = '0;
        any_miss_cnt = '0;
        hit_cnt      = '0;
        two_bit_mode = MODE_ONE_BIT;
    endtask

    // The totals stop at all ones instead of wrapping.
    function automatic logic [bdtp_pkg::FIELD_BITS-1:0] bump_total(
        input logic [bdtp_pkg::FIELD_BITS-1:0] c
    );
        return (c == '1) ? c : c + 1'b1;
    endfunction

    // Looks up the entry of one resolved branch, scores the prediction,
    // then trains the entry. Returns the result the block should report.
    function automatic bdtp_pkg::t_out resolve_branch(input bdtp_pkg::t_in b);
        bdtp_pkg::t_out r;
        int             slot;
        bdtp_pkg::t_ctr ctr;
        slot = int'(b.branch_pc % TABLE_SIZE);
        ctr  = ctr_states[slot];
        r    = '0;

        r.predicted_taken  = dir_bits[slot];
        r.predicted_target = btb_targets[slot];
        r.direction_miss   = (r.predicted_taken != b.branch_taken);
        r.target_miss      = (r.predicted_target != b.branch_target);

        if (r.direction_miss) begin
            dir_miss_cnt = bump_total(dir_miss_cnt);
        end
        if (r.target_miss) begin
            tgt_miss_cnt = bump_total(tgt_miss_cnt);
        end
        if (r.direction_miss || r.target_miss) begin
            any_miss_cnt = bump_total(any_miss_cnt);
        end else begin
            hit_cnt = bump_total(hit_cnt);
        end

        if (two_bit_mode == bdtp_pkg::MODE_TWO_BIT) begin
            case (ctr)
                bdtp_pkg::CTR_WNT, bdtp_pkg::CTR_WT: begin
                    // Weak states follow the outcome and learn the target
                    // only on a taken branch.
                    dir_bits[slot] = b.branch_taken;
                    if (b.branch_taken) begin
                        btb_targets[slot] = b.branch_target;
                        ctr_states[slot]  = (ctr == bdtp_pkg::CTR_WNT) ?
                                            bdtp_pkg::CTR_WT : bdtp_pkg::CTR_ST;
                    end else begin
                        ctr_states[slot]  = (ctr == bdtp_pkg::CTR_WNT) ?
                                            bdtp_pkg::CTR_SNT : bdtp_pkg::CTR_WNT;
                    end
                end
                bdtp_pkg::CTR_SNT: begin
                    dir_bits[slot] = 1'b0;
                    if (b.branch_taken) begin
                        ctr_states[slot] = bdtp_pkg::CTR_WNT;
                    end
                end
                default: begin
                    // Strong taken rewrites the target even when the branch
                    // fell through.
                    dir_bits[slot]    = 1'b1;
                    btb_targets[slot] = b.branch_target;
                    if (!b.branch_taken) begin
                        ctr_states[slot] = bdtp_pkg::CTR_WT;
                    end
                end
            endcase
        end else begin
            // One-bit mode leaves the counters untouched.
            dir_bits[slot] = b.branch_taken;
            if (b.branch_taken) begin
                btb_targets[slot] = b.branch_target;
            end
        end

        r.direction_miss_total = dir_miss_cnt;
        r.target_miss_total    = tgt_miss_cnt;
        r.miss_total           = any_miss_cnt;
        r.hit_total            = hit_cnt;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Mismatch reporting.
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string field, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_PRINTED) begin
            $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
                     $realtime, field, got, want, results_checked);
        end
    endtask

    // ------------------------------------------------------------------------
    // Result checker. Outputs are sampled at the rising edge, before the
    // block's registers take their new values.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        bdtp_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no branch pending", o_out_data.hit_total, '0);
            end else begin
                want = pending_results.pop_front();
                if (o_out_data.predicted_taken !== want.predicted_taken) begin
                    report_mismatch("predicted_taken", o_out_data.predicted_taken,
                                    want.predicted_taken);
                end
                if (o_out_data.predicted_target !== want.predicted_target) begin
                    report_mismatch("predicted_target", o_out_data.predicted_target,
                                    want.predicted_target);
                end
                if (o_out_data.direction_miss !== want.direction_miss) begin
                    report_mismatch("direction_miss", o_out_data.direction_miss,
                                    want.direction_miss);
                end
                if (o_out_data.target_miss !== want.target_miss) begin
                    report_mismatch("target_miss", o_out_data.target_miss, want.target_miss);
                end
                if (o_out_data.direction_miss_total !== want.direction_miss_total) begin
                    report_mismatch("direction_miss_total", o_out_data.direction_miss_total,
                                    want.direction_miss_total);
                end
                if (o_out_data.target_miss_total !== want.target_miss_total) begin
                    report_mismatch("target_miss_total", o_out_data.target_miss_total,
                                    want.target_miss_total);
                end
                if (o_out_data.miss_total !== want.miss_total) begin
                    report_mismatch("miss_total", o_out_data.miss_total, want.miss_total);
                end
                if (o_out_data.hit_total !== want.hit_total) begin
                    report_mismatch("hit_total", o_out_data.hit_total, want.hit_total);
                end
                results_checked++;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result side back-pressure. Ready changes at the falling edge; it is
    // low with a probability of 36 percent, except during the steady stretch.
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (steady) begin
            i_out_ready <= 1'b1;
        end else begin
            i_out_ready <= ($urandom_range(99) >= 36);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog. Any cycle with a transfer on either channel restarts the
    // count; a long silence means the block has hung.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] watchdog: no transfer for %0d cycles, %0d results pending",
                     $realtime, stall_cycles, pending_results.size());
            $display("Simulation FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Sender. Every task below starts and ends at a falling edge. After a
    // transfer valid is left high, so that a back-to-back branch keeps it
    // high; whoever ends a burst lowers it.
    // ------------------------------------------------------------------------
    task automatic send_branch(input logic [ADDR_BITS-1:0] pc,
                               input logic [ADDR_BITS-1:0] target, input logic taken);
        bdtp_pkg::t_in item;
        item.branch_pc     = pc;
        item.branch_target = target;
        item.branch_taken  = taken;
        while (!steady && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do begin
            @(posedge i_clk);
        end while (!o_in_ready);
        pending_results.push_back(resolve_branch(item));
        branches_sent++;
        @(negedge i_clk);
    endtask

    // Stops sending and waits until every predicted result has been checked.
    // Since each branch yields exactly one result, the block is then idle.
    task automatic drain_results();
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_results.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    // The mode register is only written while the block holds no branch.
    task automatic write_mode(input logic mode);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= mode;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        two_bit_mode = mode;
        mode_writes++;
    endtask

    function automatic logic [ADDR_BITS-1:0] random_address();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[ADDR_BITS-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // One-bit mode on cleared tables: the all-zero and all-ones addresses,
    // two PCs that share one entry, and a target change on a taken branch.
    task automatic test_one_bit_directed();
        write_mode(MODE_ONE_BIT);
        send_branch('0, '0, 1'b0);                                // Clean hit on reset state.
        send_branch('1, '1, 1'b1);                                // Both misses.
        send_branch('1, '1, 1'b1);                                // Now learned.
        send_branch(48'h0000_0000_0FFF, 48'h1234_5678_9ABC, 1'b0); // Alias of all ones.
        send_branch(48'h0000_0000_0FFF, '1, 1'b0);                // Target kept when not taken.
        send_branch(48'h0000_0000_0001, 48'hAAAA_AAAA_AAAA, 1'b1);
        send_branch(48'h8000_0000_0001, 48'h5555_5555_5555, 1'b1); // Target miss only.
        drain_results();
    endtask

    // Two-bit mode: walks one entry through all four counter states, with
    // the strong taken entry rewriting its target on a fall-through.
    task automatic test_two_bit_directed();
        write_mode(bdtp_pkg::MODE_TWO_BIT);
        send_branch(48'h0000_0000_0100, 48'h0000_0000_A000, 1'b1); // Weak NT to weak T.
        send_branch(48'h0000_0000_0100, 48'h0000_0000_A000, 1'b1); // Weak T to strong T.
        send_branch(48'h0000_0000_0100, 48'h0000_0000_B000, 1'b1); // Strong T, new target.
        send_branch(48'h0000_0000_0100, 48'h0000_0000_C000, 1'b0); // Strong T falls through.
        send_branch(48'h0000_0000_0100, 48'h0000_0000_C000, 1'b0); // Weak T to weak NT.
        send_branch(48'h0000_0000_0100, 48'h0000_0000_D000, 1'b0); // Weak NT to strong NT.
        send_branch(48'h0000_0000_0100, 48'h0000_0000_D000, 1'b0); // Strong NT holds.
        send_branch(48'h0000_0000_0100, 48'h0000_0000_E000, 1'b1); // Strong NT, target kept.
        send_branch(48'h0000_0000_0200, 48'h0000_0000_F000, 1'b1);
        send_branch(48'h0000_0000_0200, 48'h0000_0000_F000, 1'b1); // Leaves this one strong T.
        drain_results();
    endtask

    // The tables are shared between modes; one-bit mode must leave the
    // counters where two-bit mode put them.
    task automatic test_mode_switch();
        write_mode(MODE_ONE_BIT);
        send_branch(48'h0000_0000_0100, 48'h0000_0000_E000, 1'b1);
        send_branch(48'h0000_0000_0200, 48'h0000_0000_F000, 1'b0);
        write_mode(bdtp_pkg::MODE_TWO_BIT);
        send_branch(48'h0000_0000_0100, 48'h0000_0000_E000, 1'b0); // Counter still weak NT.
        send_branch(48'h0000_0000_0200, 48'h0000_0001_0000, 1'b0); // Counter still strong T.
        send_branch(48'h0000_0000_0200, 48'h0000_0001_0000, 1'b1);
        drain_results();
    endtask

    // Random traffic in phases of alternating mode. Most branches come from
    // a pool of recurring PCs, each with its own bias and a mostly stable
    // target, so that entries are trained and then hit. Some pool PCs alias
    // others in the table. The rest is noise over the whole address space.
    task automatic test_random_traffic();
        logic [ADDR_BITS-1:0] pool_pc     [POOL_SIZE];
        logic [ADDR_BITS-1:0] pool_target [POOL_SIZE];
        int                   pool_bias   [POOL_SIZE];
        int                   k;
        logic                 taken;

        for (int i = 0; i < POOL_SIZE; i++) begin
            pool_pc[i]     = random_address();
            pool_target[i] = random_address();
            case ($urandom_range(3))
                0:       pool_bias[i] = 3;
                1:       pool_bias[i] = 97;
                2:       pool_bias[i] = 50;
                default: pool_bias[i] = $urandom_range(100);
            endcase
        end
        // Upper quarter of the pool shares entries with the lower quarter.
        for (int i = 0; i < POOL_SIZE / 4; i++) begin
            pool_pc[POOL_SIZE - 1 - i][11:0] = pool_pc[i][11:0];
        end

        for (int p = 0; p < PHASES; p++) begin
            write_mode((p % 2 == 0) ? bdtp_pkg::MODE_TWO_BIT : MODE_ONE_BIT);
            // One phase runs with no idling on either side.
            steady = (p == 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Now and then the sender waits for the pipeline to empty.
                if (n % 97 == 60) begin
                    drain_results();
                end
                if ($urandom_range(99) < 15) begin
                    send_branch(random_address(), random_address(),
                                1'($urandom_range(1)));
                end else begin
                    k     = $urandom_range(POOL_SIZE - 1);
                    taken = ($urandom_range(99) < pool_bias[k]);
                    if ($urandom_range(99) < 6) begin
                        pool_target[k] = random_address();
                    end
                    send_branch(pool_pc[k], pool_target[k], taken);
                end
            end
            steady = 1'b0;
        end
        drain_results();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        clear_model();

        // Synchronous reset is held from the start, then released at a falling
        // edge. The block then clears its tables on its own.
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_one_bit_directed();
        test_two_bit_directed();
        test_mode_switch();
        test_random_traffic();

        // Anything the block produces after this point is unexpected.
        drain_results();
        repeat (2 * PIPE_LATENCY) @(negedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch("results never delivered", pending_results.size(), 0);
        end

        $display("Run covered %0d branches over %0d mode writes in both modes; %0d results checked.",
                 branches_sent, mode_writes, results_checked);
        $display("Model totals: %0d hits, %0d direction misses, %0d target misses, %0d mismatches.",
                 hit_cnt, dir_miss_cnt, tgt_miss_cnt, error_count);
        if (error_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ===== branch_direction_target_predictor.f =====
design/bdtp_pkg.sv
design/bdtp_table.sv
design/branch_direction_target_predictor.sv
tb/sv/branch_direction_target_predictor_tb.sv
